@@ rtl/prt_pkg.sv @@
package prt_pkg;

  localparam int WEIGHT_W       = 24;
  localparam int FEAT_W         = 16;
  localparam int RATE_W         = 16;
  localparam int COUNT_W        = 3;
  localparam int INDEX_W        = 5;
  localparam int FEATURE_FIELDS = 4;
  localparam int SIGN_BITS      = 4;
  localparam int PROD_W         = WEIGHT_W + FEAT_W;
  localparam int SCALED_W       = RATE_W + 2 + FEAT_W;
  localparam int ROUND_SHIFT    = 12;
  localparam int DELTA_W        = SCALED_W - ROUND_SHIFT;
  localparam int BIAS_SHIFT     = 12;
  localparam int ACC_W          = PROD_W + 4;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [RATE_W-1:0]  RATE_RESET     = 16'd655;
  localparam logic [COUNT_W-1:0] FEATURES_RESET = 3'd2;
  localparam logic [COUNT_W-1:0] OUTPUTS_RESET  = 3'd1;

  localparam logic signed [WEIGHT_W:0] W_MAX = 25'sd8388607;
  localparam logic signed [WEIGHT_W:0] W_MIN = -25'sd8388608;

  typedef enum logic [1:0] {
    OP_CLASSIFY = 2'd0,
    OP_TRAIN    = 2'd1,
    OP_WRITE    = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RATE     = 2'd0,
    CFG_FEATURES = 2'd1,
    CFG_OUTPUTS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                                   op;
    logic [FEATURE_FIELDS-1:0][FEAT_W-1:0] feature;
    logic [SIGN_BITS-1:0]                  expected;
    logic [INDEX_W-1:0]                    index;
    logic [WEIGHT_W-1:0]                   wvalue;
  } item_t;

  typedef struct packed {
    logic [RATE_W-1:0]         rate;
    logic [FEATURE_FIELDS-1:0] feat_act;
    logic [SIGN_BITS-1:0]      out_act;
  } cfg_t;

  typedef struct packed {
    logic [SIGN_BITS-1:0] en;
    logic [SIGN_BITS-1:0] up;
    logic                 wr_en;
    logic [INDEX_W-1:0]   wr_index;
    logic [WEIGHT_W-1:0]  wr_value;
  } upd_t;

  typedef logic [SIGN_BITS-1:0][FEATURE_FIELDS-1:0][PROD_W-1:0] prod_t;
  typedef logic [FEATURE_FIELDS:0][DELTA_W-1:0] delta_t;

  function automatic logic signed [WEIGHT_W-1:0] sat_weight(input logic signed [WEIGHT_W:0] v);
    logic signed [WEIGHT_W-1:0] r;
    if (v > W_MAX) begin
      r = W_MAX[WEIGHT_W-1:0];
    end else if (v < W_MIN) begin
      r = W_MIN[WEIGHT_W-1:0];
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/prt_weights.sv @@
module prt_weights #(
  parameter int MAX_FEATURES = 4,
  parameter int MAX_OUTPUTS  = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  prt_pkg::upd_t                       upd,
  input  prt_pkg::delta_t                     delta,
  output logic signed [prt_pkg::WEIGHT_W-1:0] weight [(MAX_FEATURES+1)*MAX_OUTPUTS]
);
  import prt_pkg::*;

  localparam int Depth = (MAX_FEATURES + 1) * MAX_OUTPUTS;

  logic signed [WEIGHT_W-1:0] weight_r [Depth];

  // entry k holds slot k / MAX_OUTPUTS of output k % MAX_OUTPUTS
  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam int Slot = k / MAX_OUTPUTS;
    localparam int Lane = k % MAX_OUTPUTS;

    logic                       step;
    logic signed [WEIGHT_W-1:0] stepped;
    logic signed [WEIGHT_W-1:0] weight_nxt;

    if (Slot <= FEATURE_FIELDS && Lane < SIGN_BITS) begin : g_upd
      logic signed [WEIGHT_W:0] ext_w;
      logic signed [WEIGHT_W:0] ext_d;
      logic signed [WEIGHT_W:0] sum;
      assign ext_w   = (WEIGHT_W+1)'(weight_r[k]);
      assign ext_d   = (WEIGHT_W+1)'($signed(delta[Slot]));
      assign sum     = upd.up[Lane] ? ext_w + ext_d : ext_w - ext_d;
      assign step    = upd.en[Lane];
      assign stepped = sat_weight(sum);
    end else begin : g_fixed
      // no sample input reaches this entry, so training leaves it alone
      assign step    = 1'b0;
      assign stepped = weight_r[k];
    end

    always_comb begin
      weight_nxt = weight_r[k];
      if (upd.wr_en && (32'(upd.wr_index) == k)) begin
        weight_nxt = upd.wr_value;
      end else if (step) begin
        weight_nxt = stepped;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        weight_r[k] <= '0;
      end else begin
        weight_r[k] <= weight_nxt;
      end
    end
  end

  assign weight = weight_r;

endmodule

@@ rtl/prt_mac.sv @@
module prt_mac #(
  parameter int MAX_FEATURES = 4,
  parameter int MAX_OUTPUTS  = 4
) (
  input  logic                                clk,
  input  logic                                a_load,
  input  logic                                b_load,
  input  prt_pkg::item_t                      in_item,
  input  prt_pkg::cfg_t                       cfg,
  input  logic signed [prt_pkg::WEIGHT_W-1:0] weight [(MAX_FEATURES+1)*MAX_OUTPUTS],
  output prt_pkg::item_t                      b_item,
  output prt_pkg::prod_t                      b_prod,
  output prt_pkg::delta_t                     b_delta,
  output logic [prt_pkg::WEIGHT_W-1:0]        b_readback
);
  import prt_pkg::*;

  localparam int Depth    = (MAX_FEATURES + 1) * MAX_OUTPUTS;
  localparam int NumLanes = (MAX_OUTPUTS < SIGN_BITS) ? MAX_OUTPUTS : SIGN_BITS;
  localparam int NumSlots = (MAX_FEATURES < FEATURE_FIELDS) ? MAX_FEATURES : FEATURE_FIELDS;

  item_t                a_item_r;
  item_t                b_item_r;
  prod_t                prod_nxt;
  prod_t                prod_r;
  delta_t               delta_nxt;
  delta_t               delta_r;
  logic [WEIGHT_W-1:0]  readback_nxt;
  logic [WEIGHT_W-1:0]  readback_r;
  logic signed [FEAT_W-1:0]   x [FEATURE_FIELDS];
  logic signed [RATE_W+1:0]   rate2;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_item_r <= in_item;
    end
  end

  // features past the configured count read as zero
  always_comb begin
    for (int i = 0; i < FEATURE_FIELDS; i++) begin
      x[i] = cfg.feat_act[i] ? $signed(a_item_r.feature[i]) : '0;
    end
  end

  assign rate2 = $signed({1'b0, cfg.rate, 1'b0});

  // update step per slot: 2*rate*x rounded half up to Q8.16
  assign delta_nxt[0] = DELTA_W'({cfg.rate, 1'b0});
  for (genvar s = 0; s < FEATURE_FIELDS; s++) begin : g_delta
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SCALED_W-1:0] rounded;
    assign scaled       = rate2 * x[s];
    assign rounded      = scaled + SCALED_W'(2048);
    assign delta_nxt[s+1] = rounded[SCALED_W-1:ROUND_SHIFT];
  end

  for (genvar o = 0; o < SIGN_BITS; o++) begin : g_lane
    for (genvar s = 0; s < FEATURE_FIELDS; s++) begin : g_slot
      if (o < NumLanes && s < NumSlots) begin : g_mul
        logic signed [PROD_W-1:0] p;
        assign p = weight[(s + 1) * MAX_OUTPUTS + o] * x[s];
        assign prod_nxt[o][s] = p;
      end else begin : g_zero
        assign prod_nxt[o][s] = '0;
      end
    end
  end

  always_comb begin
    readback_nxt = '0;
    for (int k = 0; k < Depth; k++) begin
      if (32'(a_item_r.index) == k) begin
        readback_nxt = weight[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_item_r   <= a_item_r;
      prod_r     <= prod_nxt;
      delta_r    <= delta_nxt;
      readback_r <= readback_nxt;
    end
  end

  assign b_item     = b_item_r;
  assign b_prod     = prod_r;
  assign b_delta    = delta_r;
  assign b_readback = readback_r;

endmodule

@@ rtl/prt_decide.sv @@
module prt_decide #(
  parameter int MAX_FEATURES = 4,
  parameter int MAX_OUTPUTS  = 4
) (
  input  logic                                clk,
  input  logic                                go,
  input  prt_pkg::cfg_t                       cfg,
  input  prt_pkg::item_t                      b_item,
  input  prt_pkg::prod_t                      b_prod,
  input  logic [prt_pkg::WEIGHT_W-1:0]        b_readback,
  input  logic signed [prt_pkg::WEIGHT_W-1:0] weight [(MAX_FEATURES+1)*MAX_OUTPUTS],
  output prt_pkg::upd_t                       upd,
  output logic [prt_pkg::SIGN_BITS-1:0]       predicted_signs,
  output logic                                mistake,
  output logic [prt_pkg::WEIGHT_W-1:0]        weight_readback
);
  import prt_pkg::*;

  localparam int NumLanes = (MAX_OUTPUTS < SIGN_BITS) ? MAX_OUTPUTS : SIGN_BITS;

  logic [SIGN_BITS-1:0] pred;
  logic [SIGN_BITS-1:0] wrong;
  logic                 is_train;
  logic                 is_sample;
  logic [SIGN_BITS-1:0] predicted_r;
  logic                 mistake_r;
  logic [WEIGHT_W-1:0]  readback_r;

  for (genvar o = 0; o < SIGN_BITS; o++) begin : g_lane
    if (o < NumLanes) begin : g_acc
      logic signed [ACC_W-1:0] acc;
      always_comb begin
        // bias input is 1.0, i.e. 4096 in Q4.12
        acc = ACC_W'(weight[o]) <<< BIAS_SHIFT;
        for (int s = 0; s < FEATURE_FIELDS; s++) begin
          acc = acc + ACC_W'($signed(b_prod[o][s]));
        end
      end
      assign pred[o] = cfg.out_act[o] & ~acc[ACC_W-1];
    end else begin : g_off
      assign pred[o] = 1'b0;
    end
  end

  assign wrong     = (pred ^ b_item.expected) & cfg.out_act;
  assign is_train  = (b_item.op == OP_TRAIN);
  assign is_sample = is_train || (b_item.op == OP_CLASSIFY);

  always_comb begin
    upd          = '0;
    upd.en       = (go && is_train) ? wrong : '0;
    upd.up       = b_item.expected;
    upd.wr_en    = go && (b_item.op == OP_WRITE);
    upd.wr_index = b_item.index;
    upd.wr_value = b_item.wvalue;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      predicted_r <= is_sample ? pred : '0;
      mistake_r   <= is_train && (|wrong);
      readback_r  <= (b_item.op == OP_READ) ? b_readback : '0;
    end
  end

  assign predicted_signs = predicted_r;
  assign mistake         = mistake_r;
  assign weight_readback = readback_r;

endmodule

@@ rtl/perceptron_rosenblatt_trainer.sv @@
// Perceptron with up to four sign outputs, trained by the Rosenblatt rule.
// Input channel (in_valid/in_ready) takes one operation word: classify,
// train, write weight or read weight. Output channel (out_valid/out_ready)
// gives one result word per input word, in order.
// Pipeline: input register -> product register (weight*feature multipliers,
// update steps) -> result register (sum, sign, weight update).
// Classify and read words stream at one per cycle unless the output stalls.
// Train and write words change the weights when they leave the product
// register, so the word behind them cannot enter the product register
// until they have left it.
// A stalled output holds its word; the input register and product register
// still fill, then in_ready drops.
// cfg_we writes learning_rate (index 0), features_used (1) or outputs_used (2)
// at once; write only while the pipeline is empty.
// Reset clears the weight table, restores the register defaults and empties
// the pipeline.
module perceptron_rosenblatt_trainer #(
  parameter int MAX_FEATURES = 4,
  parameter int MAX_OUTPUTS  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_operation,
  input  logic signed [prt_pkg::FEAT_W-1:0]      in_feature_0,
  input  logic signed [prt_pkg::FEAT_W-1:0]      in_feature_1,
  input  logic signed [prt_pkg::FEAT_W-1:0]      in_feature_2,
  input  logic signed [prt_pkg::FEAT_W-1:0]      in_feature_3,
  input  logic [prt_pkg::SIGN_BITS-1:0]          in_expected_signs,
  input  logic [prt_pkg::INDEX_W-1:0]            in_weight_index,
  input  logic signed [prt_pkg::WEIGHT_W-1:0]    in_weight_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [prt_pkg::SIGN_BITS-1:0]          out_predicted_signs,
  output logic                                   out_mistake,
  output logic signed [prt_pkg::WEIGHT_W-1:0]    out_weight_readback,
  input  logic                                   cfg_we,
  input  logic [prt_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import prt_pkg::*;

  localparam int Depth = (MAX_FEATURES + 1) * MAX_OUTPUTS;

  logic [RATE_W-1:0]  rate_r;
  logic [COUNT_W-1:0] features_used_r;
  logic [COUNT_W-1:0] outputs_used_r;
  logic [COUNT_W-1:0] features_eff;
  logic [COUNT_W-1:0] outputs_eff;
  cfg_t               cfg;

  logic a_valid_r, a_valid_nxt;
  logic b_valid_r, b_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_fire, a_go, b_go, b_mod;

  item_t               in_item;
  item_t               b_item;
  prod_t               b_prod;
  delta_t              b_delta;
  upd_t                upd;
  logic [WEIGHT_W-1:0] b_readback;
  logic [WEIGHT_W-1:0] readback;
  logic signed [WEIGHT_W-1:0] weight [Depth];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r          <= RATE_RESET;
      features_used_r <= FEATURES_RESET;
      outputs_used_r  <= OUTPUTS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RATE:     rate_r          <= cfg_wdata[RATE_W-1:0];
        CFG_FEATURES: features_used_r <= cfg_wdata[COUNT_W-1:0];
        CFG_OUTPUTS:  outputs_used_r  <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // a count of zero acts as one; the parameters cap the rest
  assign features_eff = (features_used_r == '0) ? COUNT_W'(1) : features_used_r;
  assign outputs_eff  = (outputs_used_r == '0) ? COUNT_W'(1) : outputs_used_r;

  always_comb begin
    cfg      = '0;
    cfg.rate = rate_r;
    for (int i = 0; i < FEATURE_FIELDS; i++) begin
      cfg.feat_act[i] = (i + 1 <= int'(features_eff)) && (i + 1 <= MAX_FEATURES);
    end
    for (int i = 0; i < SIGN_BITS; i++) begin
      cfg.out_act[i] = (i < int'(outputs_eff)) && (i < MAX_OUTPUTS);
    end
  end

  always_comb begin
    in_item            = '0;
    in_item.op         = op_t'(in_operation);
    in_item.feature[0] = in_feature_0;
    in_item.feature[1] = in_feature_1;
    in_item.feature[2] = in_feature_2;
    in_item.feature[3] = in_feature_3;
    in_item.expected   = in_expected_signs;
    in_item.index      = in_weight_index;
    in_item.wvalue     = in_weight_value;
  end

  // a word that changes the weights must leave before the next one multiplies
  assign b_mod    = (b_item.op == OP_TRAIN) || (b_item.op == OP_WRITE);
  assign b_go     = b_valid_r && (!out_valid_r || out_ready);
  assign a_go     = a_valid_r && (!b_valid_r || (b_go && !b_mod));
  assign in_ready = !a_valid_r || a_go;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (a_go) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (a_go) begin
      b_valid_nxt = 1'b1;
    end else if (b_go) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (b_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  prt_weights #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_weights (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .delta (b_delta),
    .weight(weight)
  );

  prt_mac #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_mac (
    .clk       (clk),
    .a_load    (in_fire),
    .b_load    (a_go),
    .in_item   (in_item),
    .cfg       (cfg),
    .weight    (weight),
    .b_item    (b_item),
    .b_prod    (b_prod),
    .b_delta   (b_delta),
    .b_readback(b_readback)
  );

  prt_decide #(
    .MAX_FEATURES(MAX_FEATURES),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_decide (
    .clk            (clk),
    .go             (b_go),
    .cfg            (cfg),
    .b_item         (b_item),
    .b_prod         (b_prod),
    .b_readback     (b_readback),
    .weight         (weight),
    .upd            (upd),
    .predicted_signs(out_predicted_signs),
    .mistake        (out_mistake),
    .weight_readback(readback)
  );

  assign out_valid           = out_valid_r;
  assign out_weight_readback = $signed(readback);

  a_mod_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    b_go && b_mod |=> !b_valid_r)
    else $error("word entered product stage behind a weight update");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    a_go |-> (!b_valid_r || b_go))
    else $error("product stage overwritten while occupied");

  a_mistake_train: assert property (@(posedge clk) disable iff (!rst_n)
    b_go && (b_item.op != OP_TRAIN) |=> !out_mistake)
    else $error("mistake flagged on a non-train word");

  a_access_pred: assert property (@(posedge clk) disable iff (!rst_n)
    b_go && ((b_item.op == OP_WRITE) || (b_item.op == OP_READ)) |=>
      (out_predicted_signs == '0))
    else $error("prediction shown on a weight access");

endmodule

@@ test/tb_perceptron_rosenblatt_trainer.sv @@
`timescale 1ns / 1ps

module tb_perceptron_rosenblatt_trainer;
  import prt_pkg::*;

  localparam int MAX_F          = 4;
  localparam int MAX_O          = 4;
  localparam int DEPTH          = (MAX_F + 1) * MAX_O;
  localparam int PHASES         = 10;
  localparam int WORDS_PER_PASS = 70;
  localparam int GAP_PCT        = 27;
  localparam int SETTLE_CYCLES  = 6;
  localparam int STUCK_LIMIT    = 2000;

  typedef struct packed {
    logic [SIGN_BITS-1:0] signs;
    logic                 mistake;
    logic [WEIGHT_W-1:0]  readback;
  } result_t;

  typedef struct packed {
    item_t   w;
    logic    typed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic signed [FEAT_W-1:0] in_feature_0 = '0;
  logic signed [FEAT_W-1:0] in_feature_1 = '0;
  logic signed [FEAT_W-1:0] in_feature_2 = '0;
  logic signed [FEAT_W-1:0] in_feature_3 = '0;
  logic [SIGN_BITS-1:0] in_expected_signs = '0;
  logic [INDEX_W-1:0] in_weight_index = '0;
  logic signed [WEIGHT_W-1:0] in_weight_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SIGN_BITS-1:0] out_predicted_signs;
  logic out_mistake;
  logic signed [WEIGHT_W-1:0] out_weight_readback;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  perceptron_rosenblatt_trainer #(
    .MAX_FEATURES(MAX_F),
    .MAX_OUTPUTS (MAX_O)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_feature_0       (in_feature_0),
    .in_feature_1       (in_feature_1),
    .in_feature_2       (in_feature_2),
    .in_feature_3       (in_feature_3),
    .in_expected_signs  (in_expected_signs),
    .in_weight_index    (in_weight_index),
    .in_weight_value    (in_weight_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_predicted_signs(out_predicted_signs),
    .out_mistake        (out_mistake),
    .out_weight_readback(out_weight_readback),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [WEIGHT_W-1:0] weights [DEPTH];
  logic [RATE_W-1:0]  rate_q  = RATE_RESET;
  logic [COUNT_W-1:0] nfeat_q = FEATURES_RESET;
  logic [COUNT_W-1:0] nout_q  = OUTPUTS_RESET;

  result_t pending_results[$];
  row_t    directed_rows[$];
  int      label_wts [SIGN_BITS][FEATURE_FIELDS+1];
  bit      no_gaps = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stuck_cycles = 0;

  initial begin
    for (int k = 0; k < DEPTH; k++) weights[k] = '0;
  end

  function automatic result_t predict_and_learn(input item_t w);
    result_t r;
    int nf, no, o, s, k;
    longint x [FEATURE_FIELDS+1];
    longint acc, d, nw;
    r = '0;
    nf = (nfeat_q == 0) ? 1 : (nfeat_q > MAX_F) ? MAX_F : int'(nfeat_q);
    no = (nout_q == 0) ? 1 : (nout_q > MAX_O) ? MAX_O : int'(nout_q);
    if (no > SIGN_BITS) no = SIGN_BITS;
    x[0] = 4096;  // bias input 1.0 in Q4.12
    for (s = 1; s <= FEATURE_FIELDS; s++)
      x[s] = (s <= nf) ? longint'($signed(w.feature[s-1])) : 0;
    if (w.op == OP_CLASSIFY || w.op == OP_TRAIN) begin
      for (o = 0; o < no; o++) begin
        acc = 0;
        for (s = 0; s <= nf; s++) acc += longint'(weights[s*MAX_O+o]) * x[s];
        if (acc >= 0) r.signs[o] = 1'b1;
      end
      if (w.op == OP_TRAIN) begin
        for (o = 0; o < no; o++) begin
          if (r.signs[o] != w.expected[o]) begin
            r.mistake = 1'b1;
            for (s = 0; s <= nf; s++) begin
              k = s * MAX_O + o;
              // 2*rate*x rounded half up to Q8.16
              d = (2 * longint'(rate_q) * x[s] + 2048) >>> 12;
              nw = longint'(weights[k]) + (w.expected[o] ? d : -d);
              if (nw > 8388607) nw = 8388607;
              if (nw < -8388608) nw = -8388608;
              weights[k] = WEIGHT_W'(nw);
            end
          end
        end
      end
    end else if (w.op == OP_WRITE) begin
      if (w.index < DEPTH) weights[w.index] = w.wvalue;
    end else begin
      if (w.index < DEPTH) r.readback = weights[w.index];
    end
    return r;
  endfunction

  // labels from a hidden linear separator, so training sequences make sense
  function automatic logic [SIGN_BITS-1:0] separator_signs(input item_t w);
    logic [SIGN_BITS-1:0] sg;
    longint acc;
    int o, k;
    for (o = 0; o < SIGN_BITS; o++) begin
      acc = longint'(label_wts[o][0]) * 4096;
      for (k = 0; k < FEATURE_FIELDS; k++)
        acc += longint'(label_wts[o][k+1]) * longint'($signed(w.feature[k]));
      sg[o] = (acc >= 0);
    end
    return sg;
  endfunction

  function automatic logic [FEAT_W-1:0] draw_feature();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return '0;
    if (r < 9) return FEAT_W'(int'($urandom_range(8192)) - 4096);
    return FEAT_W'($urandom);
  endfunction

  function automatic logic [WEIGHT_W-1:0] draw_weight();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 24'h7FFFFF;
    if (r == 1) return 24'h800000;
    if (r < 8) return WEIGHT_W'(int'($urandom_range(262144)) - 131072);
    return WEIGHT_W'($urandom);
  endfunction

  function automatic item_t draw_word();
    item_t w;
    int pick, s;
    w = '0;
    pick = $urandom_range(99);
    w.op = (pick < 45) ? OP_TRAIN : (pick < 70) ? OP_CLASSIFY :
           (pick < 85) ? OP_WRITE : OP_READ;
    for (s = 0; s < FEATURE_FIELDS; s++) w.feature[s] = draw_feature();
    w.expected = SIGN_BITS'($urandom);
    w.index = ($urandom_range(9) == 0) ? INDEX_W'($urandom)
                                       : INDEX_W'($urandom_range(DEPTH - 1));
    w.wvalue = draw_weight();
    if (w.op == OP_TRAIN && $urandom_range(99) < 70) w.expected = separator_signs(w);
    return w;
  endfunction

  function automatic row_t mk(input op_t op, input logic [FEAT_W-1:0] f0, f1, f2, f3,
                              input logic [3:0] want, input int idx, input int wval,
                              input logic typed, input logic [3:0] signs,
                              input logic mistake, input int rb);
    row_t r;
    r.w.op = op;
    r.w.feature[0] = f0;
    r.w.feature[1] = f1;
    r.w.feature[2] = f2;
    r.w.feature[3] = f3;
    r.w.expected = want;
    r.w.index = INDEX_W'(idx);
    r.w.wvalue = WEIGHT_W'(wval);
    r.typed = typed;
    r.res.signs = signs;
    r.res.mistake = mistake;
    r.res.readback = WEIGHT_W'(rb);
    return r;
  endfunction

  task automatic send_word(input item_t w, input logic typed, input result_t typed_res);
    result_t r;
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= w.op;
    in_feature_0      <= w.feature[0];
    in_feature_1      <= w.feature[1];
    in_feature_2      <= w.feature[2];
    in_feature_3      <= w.feature[3];
    in_expected_signs <= w.expected;
    in_weight_index   <= w.index;
    in_weight_value   <= w.wvalue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_and_learn(w);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // drop valid and let the pipeline run dry
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (r)
      CFG_RATE:     rate_q  = v;
      CFG_FEATURES: nfeat_q = v[COUNT_W-1:0];
      CFG_OUTPUTS:  nout_q  = v[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input result_t e, input result_t a);
    if (mismatches < 10)
      $display("%0t %s: exp signs=%h mistake=%b rb=%h, got signs=%h mistake=%b rb=%h",
               $time, what, e.signs, e.mistake, e.readback,
               a.signs, a.mistake, a.readback);
    mismatches++;
  endtask

  always @(negedge clk) out_ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_predicted_signs, out_mistake, out_weight_readback};
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.signs !== want.signs || got.mistake !== want.mistake ||
            got.readback !== want.readback)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("perceptron_rosenblatt_trainer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int phase, o, s, i;
    logic [RATE_W-1:0]  rate_v;
    logic [COUNT_W-1:0] nf_v, no_v;

    // reset state: rate 655, two features, one output
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 4'h1, 0, 0));
    // wrong on +1 with zero sample: bias moves by -2*rate only
    directed_rows.push_back(mk(OP_TRAIN, 0, 0, 0, 0, 4'h0, 0, 0, 1, 4'h1, 1, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 4'h0, 0, -1310));
    directed_rows.push_back(mk(OP_TRAIN, 0, 0, 0, 0, 4'h1, 0, 0, 1, 4'h0, 1, 0));
    // high expected bits belong to unused outputs
    directed_rows.push_back(mk(OP_TRAIN, 0, 0, 0, 0, 4'hE, 0, 0, 1, 4'h1, 1, 0));
    directed_rows.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 4, 24'h7FFFFF, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 19, 24'h800000, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 20, 123, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 31, 24'h7FFFFF, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 20, 0, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 31, 0, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 4, 0, 1, 4'h0, 0, 24'h7FFFFF));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 19, 0, 1, 4'h0, 0, 24'h800000));
    directed_rows.push_back(mk(OP_CLASSIFY, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                               0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_CLASSIFY, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_TRAIN, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                               4'hF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_TRAIN, 16'h7FFF, 16'h7FFF, 0, 0, 4'h0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 4, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 8, 24'h555555, 1, 4'h0, 0, 0));
    directed_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 8, 0, 1, 4'h0, 0, 24'h555555));
    directed_rows.push_back(mk(OP_CLASSIFY, 16'h1234, 16'hEDCC, 16'h0FFF, 16'hF001,
                               0, 0, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < directed_rows.size(); i++)
      send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      rate_v = RATE_W'($urandom_range(65535));
      nf_v   = COUNT_W'($urandom_range(7));
      no_v   = COUNT_W'($urandom_range(7));
      case (phase)
        0: begin rate_v = 16'hFFFF; nf_v = 3'd4; no_v = 3'd4; end
        1: begin rate_v = 16'd1;    nf_v = 3'd1; no_v = 3'd4; end
        2: begin rate_v = 16'd0;    nf_v = 3'd4; no_v = 3'd4; end  // flags only
        3: begin rate_v = 16'hFFFF; nf_v = 3'd0; no_v = 3'd0; end  // zero counts act as one
        4: begin nf_v = 3'd7; no_v = 3'd7; end                     // counts clamp to four
        5: begin nf_v = 3'd3; no_v = 3'd2; end
        default: ;
      endcase
      write_reg(CFG_RATE, rate_v);
      write_reg(CFG_FEATURES, {13'($urandom), nf_v});
      write_reg(CFG_OUTPUTS, {13'($urandom), no_v});
      for (o = 0; o < SIGN_BITS; o++)
        for (s = 0; s <= FEATURE_FIELDS; s++)
          label_wts[o][s] = int'($urandom_range(4000)) - 2000;
      no_gaps = (phase == 5);
      for (i = 0; i < WORDS_PER_PASS; i++) send_word(draw_word(), 1'b0, '0);
    end

    no_gaps = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("perceptron_rosenblatt_trainer regression: pass");
    end else begin
      $display("perceptron_rosenblatt_trainer regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/prt_pkg.sv
rtl/prt_weights.sv
rtl/prt_mac.sv
rtl/prt_decide.sv
rtl/perceptron_rosenblatt_trainer.sv
test/tb_perceptron_rosenblatt_trainer.sv
